// ===== design/positional_list_with_delete_unit_macros.svh =====
// ------------------------------------------------------------------------
// positional list with delete unit: assertion macros
// shared concurrent assertion forms, sampled on clk, quiet during reset
// ------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_WITH_DELETE_UNIT_MACROS_SVH
`define POSITIONAL_LIST_WITH_DELETE_UNIT_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define PLD_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define PLD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/pld_pkg.sv =====
// ------------------------------------------------------------------------
// pld_pkg
// shared widths, operation, status and result kind codes, and the cell control bundle
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

package pld_pkg;

	localparam int DEF_CAPACITY = 32;
	localparam int DATA_W       = 32;
	localparam int FUNC_W       = 3;
	localparam int POS_W        = 6;
	localparam int STATUS_W     = 2;
	localparam int ENTRY_W      = 6;

	// operation codes
	localparam logic [FUNC_W-1:0] FUNC_APPEND    = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_RM_FIRST  = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_RM_LAST   = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_RM_AT     = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_READ      = 3'd4;

	// status codes
	localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_EMPTY   = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_BAD_POS = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd3;

	// result kinds
	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_ELEM   = 1'b1;

	// per-cell control: load wins over shift
	typedef struct packed {
		logic load;
		logic shift;
	} cell_ctl_t;

endpackage

// ===== design/pld_cell.sv =====
// ------------------------------------------------------------------------
// pld_cell
// one list slot: holds, takes its right neighbor, or loads broadcast data
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

module pld_cell (
	input  logic                          clk,
	input  pld_pkg::cell_ctl_t            ctl,
	input  logic [pld_pkg::DATA_W-1:0]    load_data,
	input  logic [pld_pkg::DATA_W-1:0]    next_data,
	output logic [pld_pkg::DATA_W-1:0]    value
);

	logic [pld_pkg::DATA_W-1:0] value_q;

	// slot storage, no reset needed for payload
	always_ff @(posedge clk) begin
		priority if (ctl.load) begin
			value_q <= load_data;
		end else if (ctl.shift) begin
			value_q <= next_data;
		end else begin
			value_q <= value_q;
		end
	end

	assign value = value_q;

endmodule

// ===== design/positional_list_with_delete_unit.sv =====
// ------------------------------------------------------------------------
// positional_list_with_delete_unit
// bounded ordered list in a chain of cells with append, removals, read-out
// ------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall  | func, item_value, position
//  out     | output    | out_valid/out_stall| kind, element_value, status,
//          |           |                    | entry_count, last
//
//  append and every removal are settled in the accept cycle: the cells load or
//  shift as needed (remove-last only lowers the count) and the status beat lands in the output register
//  read-out holds the input until every entry has been sent, one element per
//  cycle unless out_stall holds the output, as the chain rotates one slot toward the head
//  reset clears the count and control; slot contents need no clearing pass
//  while the output register is valid, out_stall holds it and raises input stall
// ------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "positional_list_with_delete_unit_macros.svh"

module positional_list_with_delete_unit #(
	parameter int CAPACITY = pld_pkg::DEF_CAPACITY
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [pld_pkg::FUNC_W-1:0]            func,
	input  logic signed [pld_pkg::DATA_W-1:0]     item_value,
	input  logic [pld_pkg::POS_W-1:0]             position,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic                                  kind,
	output logic signed [pld_pkg::DATA_W-1:0]     element_value,
	output logic [pld_pkg::STATUS_W-1:0]          status,
	output logic [pld_pkg::ENTRY_W-1:0]           entry_count,
	output logic                                  last
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CNT_W > pld_pkg::ENTRY_W) ? CNT_W : pld_pkg::ENTRY_W;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_READ = 2'b10
	} state_t;

	state_t                         state_q;
	logic [CNT_W-1:0]               count_q;
	logic [CNT_W-1:0]               rd_cnt_q;
	logic                           out_valid_q;
	logic                           kind_q;
	logic [pld_pkg::DATA_W-1:0]     element_value_q;
	logic [pld_pkg::STATUS_W-1:0]   status_q;
	logic [pld_pkg::ENTRY_W-1:0]    entry_count_q;
	logic                           last_q;

	logic                           in_acc;
	logic                           out_free;
	logic                           rd_step;
	logic                           rd_last;
	logic                           do_append;
	logic                           do_rm_first;
	logic                           do_rm_at;
	logic                           resp_load;
	logic                           rd_start;
	logic [CNT_W-1:0]               cnt_d;
	logic [pld_pkg::STATUS_W-1:0]   st_d;
	logic [CMP_W-1:0]               pos_ext;
	logic [CMP_W-1:0]               cnt_ext;
	logic [CMP_W-1:0]               cnt_d_ext;
	logic [pld_pkg::DATA_W-1:0]     load_data;
	logic                           mut_acc;
	logic                           stat_out;
	logic                           elem_out;

	pld_pkg::cell_ctl_t             cell_ctl [CAPACITY];
	logic [pld_pkg::DATA_W-1:0]     cell_val [CAPACITY];
	logic [pld_pkg::DATA_W-1:0]     cell_nxt [CAPACITY];

	// handshake
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE) || (out_valid_q && out_stall);
	assign in_acc   = in_valid && !in_stall;
	assign rd_step  = (state_q == ST_READ) && out_free;
	assign rd_last  = ((rd_cnt_q + CNT_W'(1)) == count_q);

	assign pos_ext = CMP_W'(position);
	assign cnt_ext = CMP_W'(count_q);

	// decode the accepted beat: next count and status
	always_comb begin
		cnt_d       = count_q;
		st_d        = pld_pkg::STAT_OK;
		do_append   = 1'b0;
		do_rm_first = 1'b0;
		do_rm_at    = 1'b0;
		resp_load   = 1'b0;
		rd_start    = 1'b0;
		if (in_acc) begin
			unique case (func)
				pld_pkg::FUNC_APPEND: begin
					resp_load = 1'b1;
					if (count_q == CNT_W'(CAPACITY)) begin
						st_d = pld_pkg::STAT_FULL;
					end else begin
						do_append = 1'b1;
						cnt_d     = count_q + CNT_W'(1);
					end
				end
				pld_pkg::FUNC_RM_FIRST: begin
					resp_load = 1'b1;
					if (count_q == '0) begin
						st_d = pld_pkg::STAT_EMPTY;
					end else begin
						do_rm_first = 1'b1;
						cnt_d       = count_q - CNT_W'(1);
					end
				end
				pld_pkg::FUNC_RM_LAST: begin
					resp_load = 1'b1;
					if (count_q == '0) begin
						st_d = pld_pkg::STAT_EMPTY;
					end else begin
						cnt_d = count_q - CNT_W'(1);
					end
				end
				pld_pkg::FUNC_RM_AT: begin
					resp_load = 1'b1;
					if ((pos_ext == '0) || (pos_ext > cnt_ext)) begin
						st_d = pld_pkg::STAT_BAD_POS;
					end else begin
						do_rm_at = 1'b1;
						cnt_d    = count_q - CNT_W'(1);
					end
				end
				pld_pkg::FUNC_READ: begin
					if (count_q == '0) begin
						resp_load = 1'b1;
						st_d      = pld_pkg::STAT_EMPTY;
					end else begin
						rd_start = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign cnt_d_ext = CMP_W'(cnt_d);

	// broadcast data: new value on append, head value wraps to the tail on read
	assign load_data = rd_step ? cell_val[0] : item_value;

	// cell chain
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		if (g == CAPACITY - 1) begin : g_tail
			assign cell_nxt[g] = cell_val[g];
		end else begin : g_mid
			assign cell_nxt[g] = cell_val[g+1];
		end

		assign cell_ctl[g].load  = (do_append && (CNT_W'(g) == count_q))
			|| (rd_step && (CNT_W'(g + 1) == count_q));
		assign cell_ctl[g].shift = do_rm_first
			|| (do_rm_at && (CMP_W'(g + 1) >= pos_ext))
			|| (rd_step && (CNT_W'(g + 1) < count_q));

		pld_cell u_cell (
			.clk       (clk),
			.ctl       (cell_ctl[g]),
			.load_data (load_data),
			.next_data (cell_nxt[g]),
			.value     (cell_val[g])
		);
	end

	// count, read sequencer and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rd_cnt_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= cnt_d;
			unique case (state_q)
				ST_IDLE: begin
					if (rd_start) begin
						state_q  <= ST_READ;
						rd_cnt_q <= '0;
					end
				end
				ST_READ: begin
					if (rd_step) begin
						rd_cnt_q <= rd_cnt_q + CNT_W'(1);
						if (rd_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (resp_load || rd_step) begin
				out_valid_q <= 1'b1;
			end else if (out_free) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output payload register
	always_ff @(posedge clk) begin
		if (resp_load) begin
			kind_q          <= pld_pkg::KIND_STATUS;
			element_value_q <= '0;
			status_q        <= st_d;
			entry_count_q   <= cnt_d_ext[pld_pkg::ENTRY_W-1:0];
			last_q          <= 1'b1;
		end else if (rd_step) begin
			kind_q          <= pld_pkg::KIND_ELEM;
			element_value_q <= cell_val[0];
			status_q        <= pld_pkg::STAT_OK;
			entry_count_q   <= cnt_ext[pld_pkg::ENTRY_W-1:0];
			last_q          <= rd_last;
		end
	end

	assign out_valid     = out_valid_q;
	assign kind          = kind_q;
	assign element_value = element_value_q;
	assign status        = status_q;
	assign entry_count   = entry_count_q;
	assign last          = last_q;

	// terms for the checks
	assign mut_acc  = in_acc && ((func == pld_pkg::FUNC_APPEND)
		|| (func == pld_pkg::FUNC_RM_FIRST) || (func == pld_pkg::FUNC_RM_LAST)
		|| (func == pld_pkg::FUNC_RM_AT));
	assign stat_out = out_valid_q && (kind_q == pld_pkg::KIND_STATUS) && last_q;
	assign elem_out = out_valid_q && (kind_q == pld_pkg::KIND_ELEM);

	// checks
	`PLD_ASSERT_SAME(a_count_bound, 1'b1, count_q <= CNT_W'(CAPACITY), "count above capacity")
	`PLD_ASSERT_SAME(a_read_blocks_in, state_q == ST_READ, in_stall, "input open during read-out")
	`PLD_ASSERT_NEXT(a_read_count_stable, state_q == ST_READ, $stable(count_q), "count moved")
	`PLD_ASSERT_NEXT(a_mutate_reply, mut_acc, stat_out, "missing status beat")
	`PLD_ASSERT_SAME(a_elem_ok, elem_out, status_q == pld_pkg::STAT_OK, "bad element status")

endmodule
